FILE: rtl/bxds_pkg.sv
// Shared widths, register indexes and reset values for the 2x2 box downsampler.
package bxds_pkg;

    localparam int COL_W      = 12;   // source column counter
    localparam int CH_W       = 8;    // one pixel channel
    localparam int SUM_W      = 9;    // horizontal pair sum of one channel
    localparam int TOT_W      = 10;   // 2x2 sum of one channel
    localparam int NUM_CH     = 4;    // channels carried on the stream
    localparam int WL_W       = 4;    // width_log2 register
    localparam int CC_W       = 3;    // channel_count register
    localparam int WL_MAX     = 12;   // largest width_log2 honored
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int TDATA_W    = NUM_CH * CH_W;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    localparam logic [WL_W-1:0] WIDTH_LOG2_RESET    = 4'd10;
    localparam logic [CC_W-1:0] CHANNEL_COUNT_RESET = 3'd4;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [SUM_W-1:0] pair_sum_t;

endpackage

FILE: rtl/box_downsample_2x2_top.sv
// Top level of the 2x2 box-filter downsampler with its line store of pair sums.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------------
//   s_axis   | in        | tdata: in_ch0..in_ch3, tlast: last_of_frame
//   m_axis   | out       | tdata: out_ch0..out_ch3, tlast: row_end, tuser: frame_end
//   cfg      | in        | cfg_index / cfg_data, always ready
//
// One source pixel per cycle, sustained while m_tready stays high. A result for an odd-row,
// odd-column pixel beat passes the line-store read stage, then the 2x2 add into the output
// register.
// Reset clears counters, handshake state, configuration and the held pixel; the line store
// is not cleared, each entry is written by an even row before the odd row reads it.
// With m_tready low the output register holds, the read stage fills, then s_tready drops.
module box_downsample_2x2_top
    import bxds_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH = 4096,
    parameter int MAX_CHANNELS     = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // in_ch0 [7:0], in_ch1, in_ch2, in_ch3 [31:24]
    input  logic                  s_tlast,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // out_ch0 [7:0], out_ch1, out_ch2, out_ch3 [31:24]
    output logic                  m_tlast,
    output logic                  m_tuser,    // frame_end [0]

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LINE_DEPTH = (MAX_SOURCE_WIDTH / 2 > 0) ? MAX_SOURCE_WIDTH / 2 : 1;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int FIT_WL     = $clog2(MAX_SOURCE_WIDTH + 1) - 1;
    localparam int WL_CAP     = (FIT_WL < WL_MAX) ? FIT_WL : WL_MAX;
    localparam int LINE_W     = MAX_CHANNELS * SUM_W;

    // configuration
    logic [WL_W-1:0] width_log2_reg;
    logic [CC_W-1:0] channel_count_reg;

    // stream position and held even-column pixel
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             row_odd_reg;
    logic             row_odd_next;
    chan_t            held_reg [NUM_CH];

    // read stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    pair_sum_t        s1_pair_reg [MAX_CHANNELS];
    logic             s1_row_end_reg;
    logic             s1_frame_end_reg;

    // output register
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;
    logic [TDATA_W-1:0] m_data_next;
    logic               m_last_reg;
    logic               m_user_reg;

    logic [WL_W-1:0]  wl_eff;
    logic [COL_W-1:0] last_col;
    logic             row_done;
    logic             s_fire;
    logic             out_adv;
    logic             odd_col;
    logic [IDX_W-1:0] line_idx;
    logic [LINE_W-1:0] line_wdata;
    logic [LINE_W-1:0] line_rdata;
    pair_sum_t        pair [MAX_CHANNELS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg    <= WIDTH_LOG2_RESET;
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH_LOG2:    width_log2_reg    <= cfg_data;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CC_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp width to the supported range, then mask out the last column index
    always_comb begin
        if (width_log2_reg == '0) begin
            wl_eff = WL_W'(1);
        end else if (width_log2_reg > WL_W'(WL_CAP)) begin
            wl_eff = WL_W'(WL_CAP);
        end else begin
            wl_eff = width_log2_reg;
        end
        last_col = {COL_W{1'b1}} >> (WL_W'(COL_W) - wl_eff);
    end

    assign row_done = col_reg >= last_col;
    assign out_adv  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_adv;
    assign s_fire   = s_tvalid && s_tready;
    assign odd_col  = col_reg[0];
    assign line_idx = IDX_W'(col_reg >> 1);

    always_comb begin
        if (s_tlast) begin
            col_next     = '0;
            row_odd_next = 1'b0;
        end else if (row_done) begin
            col_next     = '0;
            row_odd_next = !row_odd_reg;
        end else begin
            col_next     = col_reg + COL_W'(1);
            row_odd_next = row_odd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_odd_reg <= 1'b0;
        end else if (s_fire) begin
            col_reg     <= col_next;
            row_odd_reg <= row_odd_next;
        end
    end

    for (genvar k = 0; k < NUM_CH; k++) begin : g_held
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                held_reg[k] <= '0;
            end else if (s_fire && !odd_col) begin
                held_reg[k] <= s_tdata[k*CH_W +: CH_W];
            end
        end
    end

    for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_pair
        assign pair[k] = SUM_W'(held_reg[k]) + SUM_W'(s_tdata[k*CH_W +: CH_W]);
        assign line_wdata[k*SUM_W +: SUM_W] = pair[k];
    end

    // even rows write pair sums, odd rows read them; a row lies between the two
    bxds_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (s_fire && odd_col && !row_odd_reg),
        .wr_addr (line_idx),
        .wr_data (line_wdata),
        .rd_en   (s_fire && odd_col && row_odd_reg),
        .rd_addr (line_idx),
        .rd_data (line_rdata)
    );

    always_comb begin
        if (s_fire) begin
            s1_valid_next = odd_col && row_odd_reg;
        end else if (out_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_row_end_reg   <= row_done || s_tlast;
            s1_frame_end_reg <= s_tlast;
        end
    end

    for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_s1
        always_ff @(posedge aclk) begin
            if (s_fire) begin
                s1_pair_reg[k] <= pair[k];
            end
        end
    end

    // add the stored row and take the average; unused channels go out as zero
    for (genvar k = 0; k < NUM_CH; k++) begin : g_out
        if (k < MAX_CHANNELS) begin : g_used
            logic [TOT_W-1:0] total;
            assign total = TOT_W'(line_rdata[k*SUM_W +: SUM_W]) + TOT_W'(s1_pair_reg[k]);
            assign m_data_next[k*CH_W +: CH_W] =
                (CC_W'(k) < channel_count_reg) ? total[TOT_W-1:2] : '0;
        end else begin : g_unused
            assign m_data_next[k*CH_W +: CH_W] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_data_reg <= m_data_next;
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // a frame end always closes its row
    a_frame_end_closes_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_end without row_end");

    // every odd-row, odd-column beat lands in the read stage
    a_result_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && odd_col && row_odd_reg |=> s1_valid_reg)
        else $error("result beat not captured");

    // counters restart after the last beat of a frame
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> col_reg == '0 && !row_odd_reg)
        else $error("position not cleared after frame end");

    // a waiting read stage holds while the output is stalled
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_tready |=> s1_valid_reg && $stable(line_rdata))
        else $error("read stage lost under stall");

endmodule

FILE: rtl/bxds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bxds_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
